### rtl/core/hor_pkg.sv
package hor_pkg;

    localparam int MAX_BINS_DEF   = 1024;
    localparam int WFRAC_DEF      = 16;

    localparam int EW             = 24;   // energy / count field width
    localparam int IDXW           = 10;   // read index width
    localparam int SUMW           = 48;
    localparam int LOWW           = 40;
    localparam int BCW            = 11;   // bin_count register width

    localparam logic [EW-1:0]  GRID_START_RST = 24'd0;
    localparam logic [EW-1:0]  BIN_WIDTH_RST  = 24'd768;
    localparam logic [BCW-1:0] BIN_COUNT_RST  = 11'd1000;

    localparam logic [SUMW-1:0] SUM_MAX = {SUMW{1'b1}};

    typedef enum logic [1:0] {
        CMD_ADD   = 2'd0,
        CMD_READ  = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        REG_GRID_START = 2'd0,
        REG_BIN_WIDTH  = 2'd1,
        REG_BIN_COUNT  = 2'd2,
        REG_UNUSED     = 2'd3
    } reg_idx_t;

endpackage

### rtl/core/hor_ram.sv
module hor_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/core/hor_div.sv
// Restoring divider, one quotient bit per cycle. done pulses when quo is final.
module hor_div #(
    parameter int NUM_W = 40,
    parameter int DEN_W = 24
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [NUM_W-1:0] quo,
    output logic             done
);

    localparam int CNTW = $clog2(NUM_W + 1);

    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] den_reg;
    logic [CNTW-1:0]  cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DEN_W:0]   shifted;
    logic [DEN_W:0]   diff;

    always_comb
    begin
        shifted   = {rem_reg, quo_reg[NUM_W-1]};
        diff      = shifted - {1'b0, den_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = num;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (shifted >= {1'b0, den_reg})
            begin
                rem_next = diff[DEN_W-1:0];
                quo_next = {quo_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[DEN_W-1:0];
                quo_next = {quo_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNTW'(NUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start)
        begin
            den_reg <= den;
        end
    end

    assign quo  = quo_reg;
    assign done = done_reg;

endmodule

### rtl/core/histogram_overlap_rebinner.sv
// Add item: two bin searches, each of which may run the serial divider, then for every
// overlapped bin a weight division, the multiplies and a read-modify-write of its sums.
// Read item: the bin goes to the output register, waiting while it is busy. Clear item: zeroes every bin.
// Reset (async, rst_n low) loads the register defaults and starts a clearing pass over all
// MAX_BINS entries of the bin memory; no item is accepted until it ends.
module histogram_overlap_rebinner #(
    parameter int MAX_BINS         = hor_pkg::MAX_BINS_DEF,
    parameter int WEIGHT_FRAC_BITS = hor_pkg::WFRAC_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // edge_a[23:0], edge_b[47:24], count_value[71:48], read_index[81:72]
    input  logic [87:0]  s_axis_tdata,
    // cmd[1:0]
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // bin_index[9:0], bin_count_sum[57:10], bin_variance_sum[105:58], bin_low_edge[145:106]
    output logic [151:0] m_axis_tdata,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [23:0]  cfg_data
);

    localparam int AW   = $clog2(MAX_BINS);
    localparam int CW   = $clog2(MAX_BINS + 1);
    localparam int F    = WEIGHT_FRAC_BITS;
    localparam int WTW  = F + 1;
    localparam int NUMW = hor_pkg::EW + F;
    localparam int VSH  = hor_pkg::EW - F;
    localparam int PW   = 50;   // product width of the shared 25x25 multiplier
    localparam int XW   = 42;   // extended energy width for grid edges
    localparam int SW   = hor_pkg::SUMW;

    typedef enum logic [18:0] {
        S_CLEAR   = 19'd1 << 0,
        S_IDLE    = 19'd1 << 1,
        S_END_MUL = 19'd1 << 2,
        S_END     = 19'd1 << 3,
        S_LO      = 19'd1 << 4,
        S_LO_DIV  = 19'd1 << 5,
        S_HI      = 19'd1 << 6,
        S_HI_DIV  = 19'd1 << 7,
        S_BLO_MUL = 19'd1 << 8,
        S_BLO     = 19'd1 << 9,
        S_OVL     = 19'd1 << 10,
        S_WT_DIV  = 19'd1 << 11,
        S_CMUL    = 19'd1 << 12,
        S_PMUL    = 19'd1 << 13,
        S_LMUL    = 19'd1 << 14,
        S_RD      = 19'd1 << 15,
        S_UPD     = 19'd1 << 16,
        S_RMUL    = 19'd1 << 17,
        S_RRES    = 19'd1 << 18
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [23:0] grid_start_reg, bin_width_reg;
    logic [10:0] bin_count_reg;
    logic [23:0] w_eff;
    logic [CW-1:0] n_eff;

    // item
    logic [23:0] lo_reg, lo_next, hi_reg, hi_next, sw_reg, sw_next, cnt_reg, cnt_next;
    logic [9:0]  idx_reg, idx_next;
    logic [XW-1:0] end_reg, end_next, blo_reg, blo_next;
    logic [AW-1:0] j_reg, j_next, last_reg, last_next, clr_reg, clr_next;
    logic [WTW-1:0] wt_reg, wt_next;
    logic [48:0] cterm_reg, cterm_next;
    logic [23:0] pl_reg, pl_next;
    logic [PW-1:0] vh_reg, vh_next, vterm_reg, vterm_next;
    logic [65:0] vt_full;

    // shared multiplier
    logic [24:0] mul_a, mul_b;
    logic [PW-1:0] prod_reg;

    // divider
    logic div_start, div_done;
    logic [NUMW-1:0] div_num, div_quo;
    logic [23:0] div_den;

    // memory
    logic ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [2*SW-1:0] ram_wdata, ram_rdata;

    // overlap
    logic [XW-1:0] bhi, olo, ohi;
    logic [23:0] ovl;
    logic [PW-1:0] sum_c, sum_v;
    logic [SW-1:0] sat_c, sat_v;
    logic idx_ok;
    logic [XW-1:0] low_full;

    // output
    logic out_valid_reg, out_valid_next;
    logic [9:0]  o_idx_reg, o_idx_next;
    logic [SW-1:0] o_cs_reg, o_cs_next, o_vs_reg, o_vs_next;
    logic [39:0] o_low_reg, o_low_next;

    hor_pkg::cmd_t cmd;
    logic [23:0] in_a, in_b, in_cnt;
    logic [9:0]  in_idx;

    assign cmd    = hor_pkg::cmd_t'(s_axis_tuser);
    assign in_a   = s_axis_tdata[23:0];
    assign in_b   = s_axis_tdata[47:24];
    assign in_cnt = s_axis_tdata[71:48];
    assign in_idx = s_axis_tdata[81:72];

    assign s_axis_tready = (state_reg == S_IDLE);

    always_comb
    begin
        w_eff = (bin_width_reg == '0) ? 24'd1 : bin_width_reg;
        if (bin_count_reg == '0)
        begin
            n_eff = CW'(1);
        end
        else if (32'(bin_count_reg) > MAX_BINS)
        begin
            n_eff = CW'(MAX_BINS);
        end
        else
        begin
            n_eff = CW'(bin_count_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_start_reg <= hor_pkg::GRID_START_RST;
            bin_width_reg  <= hor_pkg::BIN_WIDTH_RST;
            bin_count_reg  <= hor_pkg::BIN_COUNT_RST;
        end
        else if (cfg_we)
        begin
            case (hor_pkg::reg_idx_t'(cfg_index))
                hor_pkg::REG_GRID_START: grid_start_reg <= cfg_data;
                hor_pkg::REG_BIN_WIDTH:  bin_width_reg  <= cfg_data;
                hor_pkg::REG_BIN_COUNT:  bin_count_reg  <= cfg_data[10:0];
                default: ;
            endcase
        end
    end

    hor_div #(
        .NUM_W(NUMW),
        .DEN_W(24)
    ) u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .start(div_start),
        .num  (div_num),
        .den  (div_den),
        .quo  (div_quo),
        .done (div_done)
    );

    hor_ram #(
        .WIDTH(2 * SW),
        .DEPTH(MAX_BINS)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    always_ff @(posedge clk)
    begin
        prod_reg <= PW'(mul_a) * PW'(mul_b);
    end

    always_comb
    begin
        bhi   = blo_reg + XW'(w_eff);
        olo   = (XW'(lo_reg) > blo_reg) ? XW'(lo_reg) : blo_reg;
        ohi   = (XW'(hi_reg) < bhi) ? XW'(hi_reg) : bhi;
        ovl   = 24'(ohi - olo);
        sum_c = PW'(ram_rdata[SW-1:0]) + PW'(cterm_reg);
        sum_v = PW'(ram_rdata[2*SW-1:SW]) + vterm_reg;
        sat_c = (sum_c > PW'(hor_pkg::SUM_MAX)) ? hor_pkg::SUM_MAX : sum_c[SW-1:0];
        sat_v = (sum_v > PW'(hor_pkg::SUM_MAX)) ? hor_pkg::SUM_MAX : sum_v[SW-1:0];
        // exact floor(c*wt*wt / 2^F) from the two partial products
        vt_full  = (66'(vh_reg) << VSH) + 66'(prod_reg >> F);
        idx_ok   = 32'(idx_reg) < MAX_BINS;
        low_full = XW'(grid_start_reg) + prod_reg[XW-1:0];
    end

    always_comb
    begin
        state_next     = state_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        sw_next        = sw_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        end_next       = end_reg;
        blo_next       = blo_reg;
        j_next         = j_reg;
        last_next      = last_reg;
        clr_next       = clr_reg;
        wt_next        = wt_reg;
        cterm_next     = cterm_reg;
        pl_next        = pl_reg;
        vh_next        = vh_reg;
        vterm_next     = vterm_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        o_idx_next     = o_idx_reg;
        o_cs_next      = o_cs_reg;
        o_vs_next      = o_vs_reg;
        o_low_next     = o_low_reg;
        mul_a          = '0;
        mul_b          = '0;
        div_start      = 1'b0;
        div_num        = '0;
        div_den        = w_eff;
        ram_we         = 1'b0;
        ram_waddr      = j_reg;
        ram_wdata      = {sat_v, sat_c};
        ram_raddr      = j_reg;

        case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == AW'(MAX_BINS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    case (cmd)
                        hor_pkg::CMD_ADD:
                        begin
                            lo_next  = (in_a < in_b) ? in_a : in_b;
                            hi_next  = (in_a < in_b) ? in_b : in_a;
                            sw_next  = (in_a < in_b) ? (in_b - in_a) : (in_a - in_b);
                            cnt_next = in_cnt;
                            if (in_a != in_b)
                            begin
                                state_next = S_END_MUL;
                            end
                        end
                        hor_pkg::CMD_READ:
                        begin
                            idx_next   = in_idx;
                            state_next = S_RMUL;
                        end
                        hor_pkg::CMD_CLEAR:
                        begin
                            clr_next   = '0;
                            state_next = S_CLEAR;
                        end
                        default: ;
                    endcase
                end
            end
            S_END_MUL:
            begin
                mul_a      = 25'(n_eff);
                mul_b      = 25'(w_eff);
                state_next = S_END;
            end
            S_END:
            begin
                end_next   = XW'(grid_start_reg) + prod_reg[XW-1:0];
                state_next = S_LO;
            end
            S_LO:
            begin
                if (lo_reg <= grid_start_reg)
                begin
                    j_next     = '0;
                    state_next = S_HI;
                end
                else if (XW'(lo_reg) >= end_reg)
                begin
                    j_next     = AW'(n_eff - 1'b1);
                    state_next = S_HI;
                end
                else
                begin
                    div_start  = 1'b1;
                    div_num    = NUMW'(lo_reg - grid_start_reg);
                    state_next = S_LO_DIV;
                end
            end
            S_LO_DIV:
            begin
                if (div_done)
                begin
                    j_next     = div_quo[AW-1:0];
                    state_next = S_HI;
                end
            end
            S_HI:
            begin
                if (hi_reg <= grid_start_reg)
                begin
                    last_next  = '0;
                    state_next = S_BLO_MUL;
                end
                else if (XW'(hi_reg) >= end_reg)
                begin
                    last_next  = AW'(n_eff - 1'b1);
                    state_next = S_BLO_MUL;
                end
                else
                begin
                    div_start  = 1'b1;
                    div_num    = NUMW'(hi_reg - grid_start_reg);
                    state_next = S_HI_DIV;
                end
            end
            S_HI_DIV:
            begin
                if (div_done)
                begin
                    last_next  = div_quo[AW-1:0];
                    state_next = S_BLO_MUL;
                end
            end
            S_BLO_MUL:
            begin
                mul_a      = 25'(j_reg);
                mul_b      = 25'(w_eff);
                state_next = S_BLO;
            end
            S_BLO:
            begin
                blo_next   = XW'(grid_start_reg) + prod_reg[XW-1:0];
                state_next = S_OVL;
            end
            S_OVL:
            begin
                if (ohi > olo)
                begin
                    div_start  = 1'b1;
                    div_num    = NUMW'(ovl) << F;
                    div_den    = sw_reg;
                    state_next = S_WT_DIV;
                end
                else if (j_reg == last_reg)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    j_next   = j_reg + 1'b1;
                    blo_next = bhi;
                end
            end
            S_WT_DIV:
            begin
                if (div_done)
                begin
                    wt_next    = div_quo[WTW-1:0];
                    state_next = S_CMUL;
                end
            end
            S_CMUL:
            begin
                mul_a      = 25'(cnt_reg);
                mul_b      = 25'(wt_reg);
                state_next = S_PMUL;
            end
            S_PMUL:
            begin
                cterm_next = prod_reg[48:0];
                pl_next    = prod_reg[23:0];
                mul_a      = prod_reg[48:24];
                mul_b      = 25'(wt_reg);
                state_next = S_LMUL;
            end
            S_LMUL:
            begin
                vh_next    = prod_reg;
                mul_a      = 25'(pl_reg);
                mul_b      = 25'(wt_reg);
                state_next = S_RD;
            end
            S_RD:
            begin
                vterm_next = vt_full[PW-1:0];
                state_next = S_UPD;
            end
            S_UPD:
            begin
                ram_we = 1'b1;
                if (j_reg == last_reg)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    j_next     = j_reg + 1'b1;
                    blo_next   = bhi;
                    state_next = S_OVL;
                end
            end
            S_RMUL:
            begin
                mul_a      = 25'(idx_reg);
                mul_b      = 25'(w_eff);
                ram_raddr  = AW'(32'(idx_reg));
                state_next = S_RRES;
            end
            S_RRES:
            begin
                // keep the low edge product while the output register is busy
                mul_a = 25'(idx_reg);
                mul_b = 25'(w_eff);
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    o_idx_next     = idx_reg;
                    o_cs_next      = idx_ok ? ram_rdata[SW-1:0] : '0;
                    o_vs_next      = idx_ok ? ram_rdata[2*SW-1:SW] : '0;
                    o_low_next     = low_full[39:0];
                    state_next     = S_IDLE;
                end
                else
                begin
                    ram_raddr = AW'(32'(idx_reg));
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        sw_reg    <= sw_next;
        cnt_reg   <= cnt_next;
        idx_reg   <= idx_next;
        end_reg   <= end_next;
        blo_reg   <= blo_next;
        j_reg     <= j_next;
        last_reg  <= last_next;
        wt_reg    <= wt_next;
        cterm_reg <= cterm_next;
        pl_reg    <= pl_next;
        vh_reg    <= vh_next;
        vterm_reg <= vterm_next;
        o_idx_reg <= o_idx_next;
        o_cs_reg  <= o_cs_next;
        o_vs_reg  <= o_vs_next;
        o_low_reg <= o_low_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, o_low_reg, o_vs_reg, o_cs_reg, o_idx_reg};

    a_idle_div_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !div_done)
        else $error("divider finished with no division pending");

    a_upd_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UPD) |-> (j_reg <= last_reg))
        else $error("bin update past last overlapped bin");

    a_upd_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UPD) |-> $past(state_reg == S_RD))
        else $error("bin write without its memory read");

    a_out_from_read: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_RRES))
        else $error("result raised outside a read item");

endmodule

### tb/hor_checker.sv
module hor_checker (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [87:0]  s_axis_tdata,
    input  logic [1:0]   s_axis_tuser,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [151:0] m_axis_tdata,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [23:0]  cfg_data,
    output int           errors,
    output int           waiting
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NBINS = hor_pkg::MAX_BINS_DEF;
    localparam int FRAC  = hor_pkg::WFRAC_DEF;

    typedef struct packed {
        logic [hor_pkg::IDXW-1:0] idx;
        logic [hor_pkg::SUMW-1:0] cnt;
        logic [hor_pkg::SUMW-1:0] var_sum;
        logic [hor_pkg::LOWW-1:0] low;
    } bin_report_t;

    logic [hor_pkg::EW-1:0]   grid_start;
    logic [hor_pkg::EW-1:0]   bin_width;
    logic [hor_pkg::BCW-1:0]  bin_count;
    logic [hor_pkg::SUMW-1:0] count_acc [NBINS];
    logic [hor_pkg::SUMW-1:0] var_acc [NBINS];
    bin_report_t              pending_reports [$];

    assign waiting = pending_reports.size();

    function automatic longint unsigned width_eff();
        return (bin_width == 0) ? 1 : longint'(bin_width);
    endfunction

    function automatic longint unsigned bins_eff();
        if (bin_count == 0)
            return 1;
        if (bin_count > NBINS)
            return NBINS;
        return longint'(bin_count);
    endfunction

    function automatic longint unsigned find_bin(longint unsigned e, longint unsigned n,
                                                 longint unsigned w);
        longint unsigned grid_end;
        grid_end = grid_start + n * w;
        if (e <= grid_start)
            return 0;
        if (e >= grid_end)
            return n - 1;
        return (e - grid_start) / w;
    endfunction

    function automatic logic [hor_pkg::SUMW-1:0] sat_sum(logic [hor_pkg::SUMW-1:0] acc,
                                                         longint unsigned term);
        longint unsigned s;
        s = longint'(acc) + term;
        return (s > longint'(hor_pkg::SUM_MAX)) ? hor_pkg::SUM_MAX : s[hor_pkg::SUMW-1:0];
    endfunction

    task automatic spread_channel(longint unsigned a, longint unsigned b, longint unsigned c);
        longint unsigned lo, hi, sw, n, w, first, last, blo, bhi, olo, ohi, wt;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        sw = hi - lo;
        n = bins_eff();
        w = width_eff();
        if (sw == 0)
            return;
        first = find_bin(lo, n, w);
        last = find_bin(hi, n, w);
        for (longint unsigned j = first; j <= last && j < n; j++)
        begin
            blo = grid_start + j * w;
            bhi = blo + w;
            olo = (lo > blo) ? lo : blo;
            ohi = (hi < bhi) ? hi : bhi;
            if (ohi > olo)
            begin
                wt = ((ohi - olo) << FRAC) / sw;
                // c*wt*wt stays below 2^57, so 64 bits hold it exactly
                count_acc[j] = sat_sum(count_acc[j], c * wt);
                var_acc[j] = sat_sum(var_acc[j], (c * wt * wt) >> FRAC);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        bin_report_t     exp_r;
        bin_report_t     got_r;
        longint unsigned idx;
        if (!rst_n)
        begin
            grid_start = hor_pkg::GRID_START_RST;
            bin_width = hor_pkg::BIN_WIDTH_RST;
            bin_count = hor_pkg::BIN_COUNT_RST;
            for (int i = 0; i < NBINS; i++)
            begin
                count_acc[i] = '0;
                var_acc[i] = '0;
            end
            pending_reports.delete();
            errors = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (hor_pkg::reg_idx_t'(cfg_index))
                    hor_pkg::REG_GRID_START: grid_start = cfg_data;
                    hor_pkg::REG_BIN_WIDTH:  bin_width = cfg_data;
                    hor_pkg::REG_BIN_COUNT:  bin_count = cfg_data[hor_pkg::BCW-1:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                case (hor_pkg::cmd_t'(s_axis_tuser))
                    hor_pkg::CMD_ADD:
                        spread_channel(s_axis_tdata[23:0], s_axis_tdata[47:24],
                                       s_axis_tdata[71:48]);
                    hor_pkg::CMD_READ:
                    begin
                        idx = s_axis_tdata[81:72];
                        exp_r.idx = hor_pkg::IDXW'(idx);
                        exp_r.cnt = count_acc[idx];
                        exp_r.var_sum = var_acc[idx];
                        exp_r.low = hor_pkg::LOWW'(grid_start + idx * width_eff());
                        pending_reports.push_back(exp_r);
                    end
                    hor_pkg::CMD_CLEAR:
                        for (int i = 0; i < NBINS; i++)
                        begin
                            count_acc[i] = '0;
                            var_acc[i] = '0;
                        end
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got_r.idx = m_axis_tdata[9:0];
                got_r.cnt = m_axis_tdata[57:10];
                got_r.var_sum = m_axis_tdata[105:58];
                got_r.low = m_axis_tdata[145:106];
                if (pending_reports.size() == 0)
                begin
                    $display("%t unexpected bin report: exp none got %h", $time, got_r);
                    errors++;
                end
                else
                begin
                    exp_r = pending_reports.pop_front();
                    if (got_r.idx !== exp_r.idx)
                    begin
                        $display("%t bin_index: exp %h got %h", $time, exp_r.idx, got_r.idx);
                        errors++;
                    end
                    if (got_r.cnt !== exp_r.cnt)
                    begin
                        $display("%t bin_count_sum bin %0d: exp %h got %h", $time, exp_r.idx,
                                 exp_r.cnt, got_r.cnt);
                        errors++;
                    end
                    if (got_r.var_sum !== exp_r.var_sum)
                    begin
                        $display("%t bin_variance_sum bin %0d: exp %h got %h", $time,
                                 exp_r.idx, exp_r.var_sum, got_r.var_sum);
                        errors++;
                    end
                    if (got_r.low !== exp_r.low)
                    begin
                        $display("%t bin_low_edge bin %0d: exp %h got %h", $time, exp_r.idx,
                                 exp_r.low, got_r.low);
                        errors++;
                    end
                end
            end
        end
    end

endmodule

### tb/histogram_overlap_rebinner_test.sv
module histogram_overlap_rebinner_test;
    timeunit 1ns;
    timeprecision 1ps;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [87:0]  s_axis_tdata;
    logic [1:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [151:0] m_axis_tdata;
    logic         cfg_we;
    logic [1:0]   cfg_index;
    logic [23:0]  cfg_data;
    int           errors;
    int           waiting;

    bit              quiet;
    int              out_stall;
    int              n_add, n_read, n_clear, n_noise;
    longint unsigned g_start, g_width, g_bins;

    histogram_overlap_rebinner dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    hor_checker scoreboard (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .errors        (errors),
        .waiting       (waiting)
    );

    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("timeout");
        $display("RESULT: ERROR");
        $finish;
    end

    // result side backpressure
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 0;
            m_axis_tready <= 1'b0;
        end
        else if (out_stall > 0)
        begin
            out_stall <= out_stall - 1;
            m_axis_tready <= 1'b0;
        end
        else if (!quiet && $urandom_range(0, 5) == 0)
        begin
            out_stall <= $urandom_range(0, 4);
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    function automatic logic [23:0] rnd24();
        return 24'($urandom);
    endfunction

    function automatic logic [9:0] rnd10();
        return 10'($urandom);
    endfunction

    task automatic send(hor_pkg::cmd_t cmd, logic [23:0] a, logic [23:0] b, logic [23:0] c,
                        logic [9:0] idx);
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= cmd;
        s_axis_tdata <= {6'd0, idx, c, b, a};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        case (cmd)
            hor_pkg::CMD_ADD:   n_add++;
            hor_pkg::CMD_READ:  n_read++;
            hor_pkg::CMD_CLEAR: n_clear++;
            default:            n_noise++;
        endcase
    endtask

    // a read queued behind everything: once its report is back the block is idle
    task automatic drain();
        send(hor_pkg::CMD_READ, rnd24(), rnd24(), rnd24(), rnd10());
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (waiting != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(hor_pkg::reg_idx_t r, logic [23:0] val);
        cfg_we <= 1'b1;
        cfg_index <= r;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (r)
            hor_pkg::REG_GRID_START: g_start = val;
            hor_pkg::REG_BIN_WIDTH:  g_width = (val == 0) ? 1 : val;
            hor_pkg::REG_BIN_COUNT:
                g_bins = (val[10:0] == 0) ? 1 : (val[10:0] > 1024) ? 1024 : val[10:0];
            default: ;
        endcase
    endtask

    task automatic setup(logic [23:0] gs, logic [23:0] w, logic [23:0] n);
        drain();
        write_reg(hor_pkg::REG_GRID_START, gs);
        write_reg(hor_pkg::REG_BIN_WIDTH, w);
        write_reg(hor_pkg::REG_BIN_COUNT, n);
    endtask

    function automatic logic [23:0] clip24(longint unsigned v);
        return (v > 24'hFF_FFFF) ? 24'hFF_FFFF : v[23:0];
    endfunction

    task automatic random_items(int count);
        longint unsigned lo, hi, lim;
        logic [23:0]     cv;
        int              r;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(0, 99);
            cv = ($urandom_range(0, 3) == 0) ? 24'hFF_FFFF
                                             : 24'($urandom_range(0, 24'hFF_FFFF));
            if (r < 55)
            begin
                lim = g_bins * g_width;
                if (lim > 24'hFF_FFFF)
                    lim = 24'hFF_FFFF;
                lo = g_start + $urandom_range(0, lim - 1);
                if ($urandom_range(0, 9) == 0 && g_start > 0)
                    lo = $urandom_range(0, g_start);
                hi = ($urandom_range(0, 9) == 0) ? lo : lo + $urandom_range(1, 3 * g_width);
                if ($urandom_range(0, 1))
                    send(hor_pkg::CMD_ADD, clip24(lo), clip24(hi), cv, rnd10());
                else
                    send(hor_pkg::CMD_ADD, clip24(hi), clip24(lo), cv, rnd10());
            end
            else if (r < 85)
                send(hor_pkg::CMD_READ, rnd24(), rnd24(), rnd24(),
                     ($urandom_range(0, 4) == 0) ? rnd10() : 10'($urandom_range(0, g_bins - 1)));
            else if (r < 88)
                send(hor_pkg::CMD_CLEAR, rnd24(), rnd24(), rnd24(), rnd10());
            else if (r < 92)
                send(hor_pkg::CMD_NONE, rnd24(), rnd24(), rnd24(), rnd10());
            else
                // channel with both edges at or above 2^23, beyond the end of most grids
                send(hor_pkg::CMD_ADD, {1'b1, 23'($urandom)}, {1'b1, 23'($urandom)}, cv,
                     rnd10());
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = hor_pkg::CMD_ADD;
        cfg_we = 1'b0;
        cfg_index = hor_pkg::REG_GRID_START;
        cfg_data = '0;
        quiet = 1'b0;
        g_start = 0;
        g_width = 768;
        g_bins = 1000;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, reset defaults
        send(hor_pkg::CMD_READ, 0, 0, 0, 0);
        send(hor_pkg::CMD_ADD, 24'd2000, 24'd100, 24'd1000, 0);        // reversed edges, 3 bins
        send(hor_pkg::CMD_ADD, 24'd500, 24'd500, 24'hFF_FFFF, 0);      // zero width
        send(hor_pkg::CMD_ADD, 24'hFF_FFFF, 24'hF0_0000, 24'hFF_FFFF, 0); // beyond grid
        send(hor_pkg::CMD_ADD, 24'd768, 24'd1536, 24'hFF_FFFF, 0);     // exactly one bin
        send(hor_pkg::CMD_ADD, 24'd0, 24'd1, 24'd0, 0);
        send(hor_pkg::CMD_READ, 0, 0, 0, 10'd0);
        send(hor_pkg::CMD_READ, 0, 0, 0, 10'd1);
        send(hor_pkg::CMD_READ, 0, 0, 0, 10'd2);
        send(hor_pkg::CMD_READ, 0, 0, 0, 10'd1023);                    // past bins in use
        send(hor_pkg::CMD_NONE, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 10'h3FF);
        send(hor_pkg::CMD_ADD, 24'hFF_FFFF, 24'd0, 24'hFF_FFFF, 0);    // whole grid
        send(hor_pkg::CMD_READ, 0, 0, 0, 10'd999);
        send(hor_pkg::CMD_READ, 0, 0, 0, 10'd500);
        send(hor_pkg::CMD_CLEAR, 0, 0, 0, 0);
        send(hor_pkg::CMD_READ, 0, 0, 0, 10'd1);
        send(hor_pkg::CMD_READ, 0, 0, 0, 10'd999);
        random_items(250);

        setup(24'd1000, 24'd1, 24'd1024);
        random_items(280);

        setup(24'd0, 24'hFF_FFFF, 24'd2);
        random_items(200);

        setup(24'hFF_FFFF, 24'd0, 24'd0);
        send(hor_pkg::CMD_READ, 0, 0, 0, 10'h3FF);
        random_items(150);

        setup(24'd12345, 24'd100, 24'd2047);
        // drive bin 5 into saturation with full-weight channels
        for (int i = 0; i < 260; i++)
            send(hor_pkg::CMD_ADD, 24'd12845, 24'd12945, 24'hFF_FFFF, 0);
        send(hor_pkg::CMD_READ, 0, 0, 0, 10'd5);
        random_items(200);

        setup(24'($urandom_range(0, 24'h3F_FFFF)), 24'($urandom_range(1, 4096)),
              24'($urandom_range(1, 1024)));
        write_reg(hor_pkg::REG_UNUSED, rnd24());
        random_items(250);

        setup(24'd0, 24'd768, 24'd1000);
        quiet = 1'b1;
        random_items(200);

        drain();
        repeat (50) @(posedge clk);
        $display("covered %0d adds, %0d reads, %0d clears, %0d unused commands", n_add, n_read,
                 n_clear, n_noise);
        $display("across seven grid settings incl. unit/max widths and clamped bin counts");
        if (errors == 0 && waiting == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
